// ----- src/ghs_pkg.sv -----
// shared types, constants and helpers for the graham scan convex hull block
// used by ghs_cross and convex_hull_graham_scan; no dependencies
`timescale 1ns / 1ps

package ghs_pkg;

  localparam int MaxPoints = 64;
  localparam int CoordBits = 16;
  localparam int CoordW    = 16;
  localparam int CoordUse  = (CoordBits < CoordW) ? CoordBits : CoordW;
  localparam int IdxW      = $clog2(MaxPoints);
  localparam int CntW      = $clog2(MaxPoints + 1);
  localparam int DiffW     = CoordW + 1;
  localparam int ProdW     = 2 * DiffW;
  localparam int AccW      = ProdW + 1;
  localparam int MinHull   = 3;

  typedef struct packed {
    logic signed [CoordW-1:0] point_x;
    logic signed [CoordW-1:0] point_y;
    logic                     final_point;
  } point_in_t;

  typedef struct packed {
    logic signed [CoordW-1:0] hull_x;
    logic signed [CoordW-1:0] hull_y;
    logic                     hull_last;
    logic                     overflow_flag;
  } hull_out_t;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
  } pt_t;

  typedef struct packed {
    logic cross_pos;
    logic cross_zero;
    logic dot_pos;
  } cross_res_t;

  function automatic logic signed [CoordW-1:0] sext(input logic [CoordW-1:0] v);
    logic [CoordW-1:0] r;
    for (int i = 0; i < CoordW; i++) begin
      r[i] = (i < CoordUse) ? v[i] : v[CoordUse-1];
    end
    return $signed(r);
  endfunction

  function automatic logic signed [DiffW-1:0] diff(input logic signed [CoordW-1:0] a,
                                                   input logic signed [CoordW-1:0] b);
    logic [DiffW-1:0] ea;
    logic [DiffW-1:0] eb;
    ea = {a[CoordW-1], a};
    eb = {b[CoordW-1], b};
    return $signed(ea - eb);
  endfunction

  function automatic logic [DiffW-1:0] absd(input logic signed [DiffW-1:0] d);
    return d[DiffW-1] ? DiffW'(-d) : DiffW'(d);
  endfunction

endpackage

// ----- src/ghs_ram.sv -----
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module ghs_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/ghs_cross.sv -----
// multicycle cross and dot product unit sharing one multiplier
// depends on ghs_pkg
`timescale 1ns / 1ps

module ghs_cross (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic signed [ghs_pkg::DiffW-1:0] ux_i,
  input  logic signed [ghs_pkg::DiffW-1:0] uy_i,
  input  logic signed [ghs_pkg::DiffW-1:0] vx_i,
  input  logic signed [ghs_pkg::DiffW-1:0] vy_i,
  output logic                            done_o,
  output ghs_pkg::cross_res_t             res_o
);

  logic signed [ghs_pkg::DiffW-1:0] ux_q, uy_q, vx_q, vy_q;
  logic signed [ghs_pkg::DiffW-1:0] ma, mb;
  logic signed [ghs_pkg::ProdW-1:0] prod_q;
  logic signed [ghs_pkg::AccW-1:0]  cr_q, dt_q;
  logic [2:0]                       step_q;
  logic                             busy_q, done_q;

  always_comb begin
    case (step_q)
      3'd0:    begin ma = ux_q; mb = vy_q; end
      3'd1:    begin ma = uy_q; mb = vx_q; end
      3'd2:    begin ma = ux_q; mb = vx_q; end
      default: begin ma = uy_q; mb = vy_q; end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 3'd1;
        if (step_q == 3'd4) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ux_q <= ux_i;
      uy_q <= uy_i;
      vx_q <= vx_i;
      vy_q <= vy_i;
    end else if (busy_q) begin
      prod_q <= ma * mb;
      case (step_q)
        3'd1:    cr_q <= ghs_pkg::AccW'(prod_q);
        3'd2:    cr_q <= cr_q - ghs_pkg::AccW'(prod_q);
        3'd3:    dt_q <= ghs_pkg::AccW'(prod_q);
        3'd4:    dt_q <= dt_q + ghs_pkg::AccW'(prod_q);
        default: ;
      endcase
    end
  end

  assign done_o           = done_q;
  assign res_o.cross_zero = (cr_q == '0);
  assign res_o.cross_pos  = !cr_q[ghs_pkg::AccW-1] && (cr_q != '0);
  assign res_o.dot_pos    = !dt_q[ghs_pkg::AccW-1] && (dt_q != '0);

  ast_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q)) else $error("cross done without work");
  ast_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("cross started while busy");
  ast_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("cross done while busy");

endmodule

// ----- src/convex_hull_graham_scan.sv -----
// convex hull of a point set by graham scan, exact integer arithmetic
// depends on ghs_pkg, ghs_ram, ghs_cross
//
// usage: points enter on the in channel (valid/ready), one per transfer,
// the one with final_point set closing the set. up to 64 points are kept;
// more are dropped and overflow_flag is set on every vertex of that set.
// loading takes one cycle per point. after the closing transfer the input
// stalls while the block finds the base, copies the other points,
// insertion sorts them by angle with the shared cross product unit,
// removes repeats and runs the scan. vertices then leave on the out
// channel, each one only once the output register is free, base last
// with hull_last set; sets of fewer than three points are echoed. an
// output register holds each vertex while the receiver stalls; the next
// set can load as soon as the last vertex sits in that register. reset
// empties the point count and returns to loading; memories need no
// clearing.
`timescale 1ns / 1ps

module convex_hull_graham_scan (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ghs_pkg::point_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ghs_pkg::hull_out_t  out_data_o
);

  localparam logic [4:0] SLoad     = 5'd0;
  localparam logic [4:0] SEchoRd   = 5'd1;
  localparam logic [4:0] SEchoWr   = 5'd2;
  localparam logic [4:0] SBaseRd   = 5'd3;
  localparam logic [4:0] SBaseChk  = 5'd4;
  localparam logic [4:0] SCopyRd   = 5'd5;
  localparam logic [4:0] SCopyChk  = 5'd6;
  localparam logic [4:0] SSortRdT  = 5'd7;
  localparam logic [4:0] SSortGetT = 5'd8;
  localparam logic [4:0] SSortRdC  = 5'd9;
  localparam logic [4:0] SSortCmp  = 5'd10;
  localparam logic [4:0] SSortWait = 5'd11;
  localparam logic [4:0] SDedupRd  = 5'd12;
  localparam logic [4:0] SDedupChk = 5'd13;
  localparam logic [4:0] SScanRd   = 5'd14;
  localparam logic [4:0] SScanGet  = 5'd15;
  localparam logic [4:0] SScanTest = 5'd16;
  localparam logic [4:0] SScanWait = 5'd17;
  localparam logic [4:0] SPopGet   = 5'd18;
  localparam logic [4:0] SOutRd    = 5'd19;
  localparam logic [4:0] SOutWr    = 5'd20;
  localparam logic [4:0] SOutBase  = 5'd21;

  localparam int CntW = ghs_pkg::CntW;
  localparam int IdxW = ghs_pkg::IdxW;

  logic [4:0]      state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d, i_q, i_d, j_q, j_d, m_q, m_d, sd_q, sd_d;
  logic            ovf_q, ovf_d;
  ghs_pkg::pt_t    base_q, base_d, t_q, t_d, c_q, c_d, a_q, a_d, b_q, b_d;
  logic            out_vld_q, out_vld_d;
  ghs_pkg::hull_out_t out_q, out_d;

  logic               pts_we;
  logic [IdxW-1:0]    pts_waddr;
  ghs_pkg::pt_t       pts_wdata, pts_rd;
  logic               wrk_we;
  logic [IdxW-1:0]    wrk_waddr, wrk_raddr;
  ghs_pkg::pt_t       wrk_wdata, wrk_rd;

  logic                             cx_start, cx_done;
  logic signed [ghs_pkg::DiffW-1:0] cx_ux, cx_uy, cx_vx, cx_vy;
  ghs_pkg::cross_res_t              cx_res;

  logic            in_xfer, out_load;
  logic [CntW-1:0] cnt_inc, i_inc, jm1, sdm3;
  logic [ghs_pkg::DiffW:0] l1_t, l1_c;

  assign in_xfer = in_valid_i && in_ready_o;
  assign cnt_inc = cnt_q + CntW'(1);
  assign i_inc   = i_q + CntW'(1);
  assign jm1     = j_q - CntW'(1);
  assign sdm3    = sd_q - CntW'(3);

  assign l1_t = (ghs_pkg::DiffW+1)'(ghs_pkg::absd(ghs_pkg::diff(t_q.x, base_q.x)))
              + (ghs_pkg::DiffW+1)'(ghs_pkg::absd(ghs_pkg::diff(t_q.y, base_q.y)));
  assign l1_c = (ghs_pkg::DiffW+1)'(ghs_pkg::absd(ghs_pkg::diff(c_q.x, base_q.x)))
              + (ghs_pkg::DiffW+1)'(ghs_pkg::absd(ghs_pkg::diff(c_q.y, base_q.y)));

  assign pts_we      = in_xfer && (cnt_q < CntW'(ghs_pkg::MaxPoints));
  assign pts_waddr   = cnt_q[IdxW-1:0];
  assign pts_wdata.x = ghs_pkg::sext(in_data_i.point_x);
  assign pts_wdata.y = ghs_pkg::sext(in_data_i.point_y);

  ghs_ram #(.Width($bits(ghs_pkg::pt_t)), .Depth(ghs_pkg::MaxPoints)) u_pts_ram (
    .clk_i   (clk_i),
    .we_i    (pts_we),
    .waddr_i (pts_waddr),
    .wdata_i (pts_wdata),
    .raddr_i (i_q[IdxW-1:0]),
    .rdata_o (pts_rd)
  );

  ghs_ram #(.Width($bits(ghs_pkg::pt_t)), .Depth(ghs_pkg::MaxPoints)) u_wrk_ram (
    .clk_i   (clk_i),
    .we_i    (wrk_we),
    .waddr_i (wrk_waddr),
    .wdata_i (wrk_wdata),
    .raddr_i (wrk_raddr),
    .rdata_o (wrk_rd)
  );

  ghs_cross u_cross (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cx_start),
    .ux_i    (cx_ux),
    .uy_i    (cx_uy),
    .vx_i    (cx_vx),
    .vy_i    (cx_vy),
    .done_o  (cx_done),
    .res_o   (cx_res)
  );

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    ovf_d     = ovf_q;
    i_d       = i_q;
    j_d       = j_q;
    m_d       = m_q;
    sd_d      = sd_q;
    base_d    = base_q;
    t_d       = t_q;
    c_d       = c_q;
    a_d       = a_q;
    b_d       = b_q;
    out_vld_d = out_vld_q && !out_ready_i;
    out_d     = out_q;
    out_load  = 1'b0;
    wrk_we    = 1'b0;
    wrk_waddr = i_q[IdxW-1:0];
    wrk_wdata = c_q;
    wrk_raddr = i_q[IdxW-1:0];
    cx_start  = 1'b0;
    cx_ux     = ghs_pkg::diff(b_q.x, a_q.x);
    cx_uy     = ghs_pkg::diff(b_q.y, a_q.y);
    cx_vx     = ghs_pkg::diff(c_q.x, b_q.x);
    cx_vy     = ghs_pkg::diff(c_q.y, b_q.y);

    unique case (state_q)
      SLoad: begin
        if (in_xfer) begin
          if (pts_we) begin
            cnt_d = cnt_inc;
          end else begin
            ovf_d = 1'b1;
          end
          if (in_data_i.final_point) begin
            i_d     = '0;
            state_d = (cnt_d < CntW'(ghs_pkg::MinHull)) ? SEchoRd : SBaseRd;
          end
        end
      end
      SEchoRd: begin
        if (!out_vld_q) state_d = SEchoWr;
      end
      SEchoWr: begin
        out_load            = 1'b1;
        out_d.hull_x        = pts_rd.x;
        out_d.hull_y        = pts_rd.y;
        out_d.hull_last     = (i_inc == cnt_q);
        out_d.overflow_flag = ovf_q;
        i_d                 = i_inc;
        if (i_inc == cnt_q) begin
          cnt_d   = '0;
          ovf_d   = 1'b0;
          state_d = SLoad;
        end else begin
          state_d = SEchoRd;
        end
      end
      SBaseRd: state_d = SBaseChk;
      SBaseChk: begin
        if (i_q == '0 || pts_rd.y < base_q.y ||
            (pts_rd.y == base_q.y && pts_rd.x > base_q.x)) begin
          base_d = pts_rd;
        end
        i_d = i_inc;
        if (i_inc == cnt_q) begin
          i_d     = '0;
          m_d     = '0;
          state_d = SCopyRd;
        end else begin
          state_d = SBaseRd;
        end
      end
      SCopyRd: state_d = SCopyChk;
      SCopyChk: begin
        if (pts_rd != base_q) begin
          wrk_we    = 1'b1;
          wrk_waddr = m_q[IdxW-1:0];
          wrk_wdata = pts_rd;
          m_d       = m_q + CntW'(1);
        end
        i_d = i_inc;
        if (i_inc == cnt_q) begin
          i_d     = CntW'(1);
          state_d = SSortRdT;
        end else begin
          state_d = SCopyRd;
        end
      end
      SSortRdT: begin
        if (i_q >= m_q) begin
          i_d     = '0;
          j_d     = '0;
          state_d = SDedupRd;
        end else begin
          state_d = SSortGetT;
        end
      end
      SSortGetT: begin
        t_d     = wrk_rd;
        j_d     = i_q;
        state_d = SSortRdC;
      end
      SSortRdC: begin
        wrk_raddr = jm1[IdxW-1:0];
        if (j_q == '0) begin
          wrk_we    = 1'b1;
          wrk_waddr = '0;
          wrk_wdata = t_q;
          i_d       = i_inc;
          state_d   = SSortRdT;
        end else begin
          state_d = SSortCmp;
        end
      end
      SSortCmp: begin
        c_d      = wrk_rd;
        cx_start = 1'b1;
        cx_ux    = ghs_pkg::diff(t_q.x, base_q.x);
        cx_uy    = ghs_pkg::diff(t_q.y, base_q.y);
        cx_vx    = ghs_pkg::diff(wrk_rd.x, base_q.x);
        cx_vy    = ghs_pkg::diff(wrk_rd.y, base_q.y);
        state_d  = SSortWait;
      end
      SSortWait: begin
        if (cx_done) begin
          wrk_we    = 1'b1;
          wrk_waddr = j_q[IdxW-1:0];
          if (cx_res.cross_pos || (cx_res.cross_zero && l1_t < l1_c)) begin
            wrk_wdata = c_q;
            j_d       = jm1;
            state_d   = SSortRdC;
          end else begin
            wrk_wdata = t_q;
            i_d       = i_inc;
            state_d   = SSortRdT;
          end
        end
      end
      SDedupRd: begin
        if (i_q >= m_q) begin
          m_d     = j_q;
          i_d     = '0;
          sd_d    = '0;
          state_d = SScanRd;
        end else begin
          state_d = SDedupChk;
        end
      end
      SDedupChk: begin
        if (j_q == '0 || wrk_rd != t_q) begin
          wrk_we    = 1'b1;
          wrk_waddr = j_q[IdxW-1:0];
          wrk_wdata = wrk_rd;
          t_d       = wrk_rd;
          j_d       = j_q + CntW'(1);
        end
        i_d     = i_inc;
        state_d = SDedupRd;
      end
      SScanRd: begin
        if (i_q >= m_q) begin
          i_d     = '0;
          state_d = SOutRd;
        end else begin
          state_d = SScanGet;
        end
      end
      SScanGet: begin
        c_d     = wrk_rd;
        state_d = SScanTest;
      end
      SScanTest: begin
        if (sd_q < CntW'(2)) begin
          wrk_we    = 1'b1;
          wrk_waddr = sd_q[IdxW-1:0];
          a_d       = b_q;
          b_d       = c_q;
          sd_d      = sd_q + CntW'(1);
          i_d       = i_inc;
          state_d   = SScanRd;
        end else begin
          cx_start = 1'b1;
          state_d  = SScanWait;
        end
      end
      SScanWait: begin
        wrk_raddr = sdm3[IdxW-1:0];
        if (cx_done) begin
          if (cx_res.cross_pos || (cx_res.cross_zero && cx_res.dot_pos)) begin
            wrk_we    = 1'b1;
            wrk_waddr = sd_q[IdxW-1:0];
            a_d       = b_q;
            b_d       = c_q;
            sd_d      = sd_q + CntW'(1);
            i_d       = i_inc;
            state_d   = SScanRd;
          end else begin
            sd_d    = sd_q - CntW'(1);
            b_d     = a_q;
            state_d = (sd_q >= CntW'(3)) ? SPopGet : SScanTest;
          end
        end
      end
      SPopGet: begin
        a_d     = wrk_rd;
        state_d = SScanTest;
      end
      SOutRd: begin
        if (i_q >= sd_q) begin
          state_d = SOutBase;
        end else if (!out_vld_q) begin
          state_d = SOutWr;
        end
      end
      SOutWr: begin
        out_load            = 1'b1;
        out_d.hull_x        = wrk_rd.x;
        out_d.hull_y        = wrk_rd.y;
        out_d.hull_last     = 1'b0;
        out_d.overflow_flag = ovf_q;
        i_d                 = i_inc;
        state_d             = SOutRd;
      end
      SOutBase: begin
        if (!out_vld_q) begin
          out_load            = 1'b1;
          out_d.hull_x        = base_q.x;
          out_d.hull_y        = base_q.y;
          out_d.hull_last     = 1'b1;
          out_d.overflow_flag = ovf_q;
          cnt_d               = '0;
          ovf_d               = 1'b0;
          state_d             = SLoad;
        end
      end
      default: state_d = SLoad;
    endcase

    if (out_load) out_vld_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= SLoad;
      cnt_q     <= '0;
      ovf_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      ovf_q     <= ovf_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q    <= i_d;
    j_q    <= j_d;
    m_q    <= m_d;
    sd_q   <= sd_d;
    base_q <= base_d;
    t_q    <= t_d;
    c_q    <= c_d;
    a_q    <= a_d;
    b_q    <= b_d;
    out_q  <= out_d;
  end

  assign in_ready_o  = (state_q == SLoad);
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  ast_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(ghs_pkg::MaxPoints)) else $error("point count beyond store");
  ast_stack_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SScanTest) |-> (sd_q <= i_q)) else $error("stack overtakes sorted list");
  ast_cross_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cx_done |-> (state_q == SSortWait || state_q == SScanWait))
    else $error("cross result outside a wait state");
  ast_last_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && out_d.hull_last) |=> (state_q == SLoad && cnt_q == '0))
    else $error("set not closed after last vertex");
  ast_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> !out_vld_q) else $error("output register overwritten");

endmodule
